>>> src/sfrd_pkg.sv
// Package for the file-receive deframer: word types, opcodes, result kinds,
// slot phases and message tags. No dependencies.
package sfrd_pkg;

    localparam int SLOTS_DEFAULT = 4;
    localparam int FIFO_DEPTH    = 4;

    localparam logic [2:0] OP_OPEN  = 3'd0;
    localparam logic [2:0] OP_READY = 3'd1;
    localparam logic [2:0] OP_BYTE  = 3'd2;
    localparam logic [2:0] OP_LOST  = 3'd3;
    localparam logic [2:0] OP_CLOSE = 3'd4;

    localparam logic [2:0] KIND_PAYLOAD = 3'd0;
    localparam logic [2:0] KIND_EOF     = 3'd1;
    localparam logic [2:0] KIND_ERROR   = 3'd2;
    localparam logic [2:0] KIND_OPENED  = 3'd3;
    localparam logic [2:0] KIND_NOFREE  = 3'd4;
    localparam logic [2:0] KIND_SEND    = 3'd5;

    localparam logic [2:0] PH_FREE = 3'd0;
    localparam logic [2:0] PH_OPEN = 3'd1;
    localparam logic [2:0] PH_HEAD = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_FAIL = 3'd4;

    localparam logic [31:0] HDR_LEN  = 32'd8;
    localparam logic [31:0] TAG_DATA = 32'h41544144;
    localparam logic [31:0] TAG_DONE = 32'h454E4F44;
    localparam logic [31:0] TAG_FAIL = 32'h4C494146;
    localparam logic [31:0] TAG_RECV = 32'h56434552;

    typedef struct packed {
        logic [2:0] opcode;
        logic [1:0] slot;
        logic [7:0] rx_byte;
        logic       chunk_end;
    } item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] result_slot;
        logic [7:0] payload_byte;
        logic       close_channel;
        logic       last_result;
    } result_t;

    // One slot's entry in the state memory; header holds id low, size high.
    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] remaining;
        logic [63:0] header;
    } entry_t;

    function automatic result_t make_result(logic [2:0] kind, logic [1:0] slot,
                                            logic [7:0] data, logic cl);
        result_t r;
        r.kind          = kind;
        r.result_slot   = slot;
        r.payload_byte  = data;
        r.close_channel = cl;
        r.last_result   = 1'b0;
        return r;
    endfunction

endpackage

>>> src/sync_file_receive_deframer.sv
// File-receive deframer top level: slot state memory, read-modify-write stage
// and result queue. Depends on sfrd_pkg.
//
// Usage: each word on the item channel is one event (open, channel ready,
// received byte, channel lost, software close) for a file slot. Each event
// gives zero, one or two words on the result channel; the last of them has
// last_result set. Both channels use valid/ready.
// Operation: the slot entry is read from a synchronous memory at the accept
// edge, updated in the update stage and written back, with the results
// pushed into a four-word queue whose head drives the result channel.
// Throughput: one item per cycle unless the result queue holds the update
// stage. Consecutive items for the same slot are forwarded from the write-back
// port, so no bubble is needed. Two results of one item use two queue entries.
// Reset: all slots are free; busy flags in flip-flops clear at once, so no
// clearing pass over the memory is needed.
// Stall: when the receiver holds result_ready low the queue fills; the update
// stage holds once fewer than two queue entries are free, and item_ready
// drops while it holds.
module sync_file_receive_deframer #(
    parameter int SLOTS = sfrd_pkg::SLOTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  sfrd_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_ready,
    output sfrd_pkg::result_t  result
);

    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LIM = (SLOTS < 4) ? SLOTS : 4;
    localparam int PW  = $clog2(sfrd_pkg::FIFO_DEPTH);
    localparam int CW  = PW + 1;

    sfrd_pkg::entry_t  mem_reg [SLOTS];
    sfrd_pkg::entry_t  rd_word_reg;
    sfrd_pkg::entry_t  fwd_word_reg;
    logic              fwd_hit_reg;
    logic              s1_valid_reg;
    sfrd_pkg::item_t   s1_item_reg;
    logic [SLOTS-1:0]  busy_reg;

    sfrd_pkg::result_t fifo_reg [sfrd_pkg::FIFO_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    logic              item_fire;
    logic              s1_fire;
    logic              pop;
    logic [SW-1:0]     in_idx;
    logic [SW-1:0]     cur_idx;
    logic [SW-1:0]     wr_idx;
    logic              wr_en;
    logic              upd;
    logic              in_range;
    sfrd_pkg::entry_t  word;
    sfrd_pkg::entry_t  new_word;
    logic [2:0]        ph;
    logic [31:0]       rem;
    logic [31:0]       rem_dec;
    logic [2:0]        pos;
    logic [63:0]       hdr_new;
    logic [1:0]        open_idx;
    logic              open_found;
    logic [1:0]        n_res;
    sfrd_pkg::result_t res0;
    sfrd_pkg::result_t res1;
    logic [CW-1:0]     count_next;

    assign item_fire    = item_valid && item_ready;
    assign s1_fire      = s1_valid_reg && (count_reg <= CW'(sfrd_pkg::FIFO_DEPTH - 2));
    assign item_ready   = !s1_valid_reg || s1_fire;
    assign in_idx       = SW'(item.slot);
    assign cur_idx      = SW'(s1_item_reg.slot);
    assign result_valid = (count_reg != '0);
    assign result       = fifo_reg[rd_ptr_reg];
    assign pop          = result_valid && result_ready;

    always_comb
    begin
        word       = fwd_hit_reg ? fwd_word_reg : rd_word_reg;
        ph         = busy_reg[cur_idx] ? word.phase : sfrd_pkg::PH_FREE;
        rem        = busy_reg[cur_idx] ? word.remaining : 32'd0;
        rem_dec    = (rem > 32'd1) ? rem - 32'd1 : 32'd0;
        in_range   = ({5'd0, s1_item_reg.slot} < 7'(SLOTS));
        new_word   = word;
        new_word.phase     = ph;
        new_word.remaining = rem;
        upd        = 1'b0;
        wr_idx     = cur_idx;
        n_res      = 2'd0;
        res0       = sfrd_pkg::make_result(sfrd_pkg::KIND_ERROR, s1_item_reg.slot,
                                           8'd0, 1'b1);
        res1       = res0;

        // Lowest free slot among those that result_slot can name.
        open_found = 1'b0;
        open_idx   = 2'd0;
        for (int i = 0; i < LIM; i++)
        begin
            if (!open_found && !busy_reg[i])
            begin
                open_found = 1'b1;
                open_idx   = 2'(i);
            end
        end

        pos = ((rem == 32'd0) || (rem > sfrd_pkg::HDR_LEN)) ? 3'd0
            : 3'(sfrd_pkg::HDR_LEN[3:0] - rem[3:0]);
        for (int b = 0; b < 8; b++)
        begin
            hdr_new[8*b +: 8] = (pos == 3'(b)) ? s1_item_reg.rx_byte : word.header[8*b +: 8];
        end

        if (s1_item_reg.opcode == sfrd_pkg::OP_OPEN)
        begin
            n_res = 2'd1;
            if (open_found)
            begin
                upd                = 1'b1;
                wr_idx             = SW'(open_idx);
                new_word.phase     = sfrd_pkg::PH_OPEN;
                new_word.remaining = 32'd0;
                res0 = sfrd_pkg::make_result(sfrd_pkg::KIND_OPENED, open_idx, 8'd0, 1'b0);
            end
            else
            begin
                res0 = sfrd_pkg::make_result(sfrd_pkg::KIND_NOFREE, 2'd0, 8'd0, 1'b0);
            end
        end
        else if (in_range)
        begin
            case (s1_item_reg.opcode)
                sfrd_pkg::OP_READY:
                begin
                    if (ph == sfrd_pkg::PH_OPEN)
                    begin
                        upd                = 1'b1;
                        new_word.phase     = sfrd_pkg::PH_HEAD;
                        new_word.remaining = sfrd_pkg::HDR_LEN;
                        n_res              = 2'd1;
                        res0 = sfrd_pkg::make_result(sfrd_pkg::KIND_SEND, s1_item_reg.slot,
                                                     8'd0, 1'b0);
                    end
                end
                sfrd_pkg::OP_BYTE:
                begin
                    upd = 1'b1;
                    case (ph)
                        sfrd_pkg::PH_HEAD:
                        begin
                            new_word.header    = hdr_new;
                            new_word.remaining = rem_dec;
                            if (rem_dec == 32'd0)
                            begin
                                if ((hdr_new[31:0] == sfrd_pkg::TAG_DATA)
                                    || (hdr_new[31:0] == sfrd_pkg::TAG_DONE))
                                begin
                                    if (hdr_new[63:32] != 32'd0)
                                    begin
                                        new_word.phase     = sfrd_pkg::PH_DATA;
                                        new_word.remaining = hdr_new[63:32];
                                    end
                                    else if (hdr_new[31:0] == sfrd_pkg::TAG_DATA)
                                    begin
                                        new_word.remaining = sfrd_pkg::HDR_LEN;
                                    end
                                    else
                                    begin
                                        new_word.phase = sfrd_pkg::PH_FREE;
                                        n_res          = 2'd1;
                                        if (s1_item_reg.chunk_end)
                                        begin
                                            res0.kind = sfrd_pkg::KIND_EOF;
                                        end
                                    end
                                end
                                else if ((hdr_new[31:0] == sfrd_pkg::TAG_FAIL)
                                         && (hdr_new[63:32] != 32'd0))
                                begin
                                    new_word.phase     = sfrd_pkg::PH_FAIL;
                                    new_word.remaining = hdr_new[63:32];
                                end
                                else
                                begin
                                    new_word.phase = sfrd_pkg::PH_FREE;
                                    n_res          = 2'd1;
                                end
                            end
                        end
                        sfrd_pkg::PH_DATA:
                        begin
                            res0 = sfrd_pkg::make_result(sfrd_pkg::KIND_PAYLOAD,
                                                         s1_item_reg.slot,
                                                         s1_item_reg.rx_byte, 1'b0);
                            n_res              = 2'd1;
                            new_word.remaining = rem_dec;
                            if (rem_dec == 32'd0)
                            begin
                                if (word.header[31:0] == sfrd_pkg::TAG_DONE)
                                begin
                                    new_word.phase = sfrd_pkg::PH_FREE;
                                    n_res          = 2'd2;
                                    if (s1_item_reg.chunk_end)
                                    begin
                                        res1.kind = sfrd_pkg::KIND_EOF;
                                    end
                                end
                                else
                                begin
                                    new_word.phase     = sfrd_pkg::PH_HEAD;
                                    new_word.remaining = sfrd_pkg::HDR_LEN;
                                end
                            end
                        end
                        sfrd_pkg::PH_FAIL:
                        begin
                            new_word.remaining = rem_dec;
                            if (rem_dec == 32'd0)
                            begin
                                new_word.phase = sfrd_pkg::PH_FREE;
                                n_res          = 2'd1;
                            end
                        end
                        default:
                        begin
                            new_word.phase = sfrd_pkg::PH_FREE;
                            n_res          = 2'd1;
                        end
                    endcase
                end
                sfrd_pkg::OP_LOST:
                begin
                    upd                = 1'b1;
                    new_word.phase     = sfrd_pkg::PH_FREE;
                    n_res              = 2'd1;
                    res0.close_channel = 1'b0;
                end
                sfrd_pkg::OP_CLOSE:
                begin
                    if (ph != sfrd_pkg::PH_FREE)
                    begin
                        upd            = 1'b1;
                        new_word.phase = sfrd_pkg::PH_FREE;
                        n_res          = 2'd1;
                    end
                end
                default:
                begin
                    upd = 1'b0;
                end
            endcase
        end

        // A freed slot returns to its reset values.
        if (new_word.phase == sfrd_pkg::PH_FREE)
        begin
            new_word.remaining = 32'd0;
            new_word.header    = 64'd0;
        end

        if (n_res == 2'd1)
        begin
            res0.last_result = 1'b1;
        end
        res1.last_result = 1'b1;

        wr_en = s1_fire && upd;
    end

    // Slot state memory: one write port from the update stage, one read port
    // with registered data.
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            rd_word_reg  <= mem_reg[in_idx];
            fwd_word_reg <= new_word;
        end
        if (wr_en)
        begin
            mem_reg[wr_idx] <= new_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_item_reg <= item;
        end
        if (s1_fire && (n_res != 2'd0))
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (s1_fire && (n_res == 2'd2))
        begin
            fifo_reg[wr_ptr_reg + PW'(1)] <= res1;
        end
    end

    always_comb
    begin
        count_next = count_reg + (s1_fire ? CW'(n_res) : CW'(0)) - (pop ? CW'(1) : CW'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            busy_reg     <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (item_fire)
            begin
                s1_valid_reg <= 1'b1;
                // The write at this edge is not seen by the read; keep it aside.
                fwd_hit_reg  <= wr_en && (wr_idx == in_idx);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                busy_reg[wr_idx] <= (new_word.phase != sfrd_pkg::PH_FREE);
            end
            if (s1_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(n_res);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> dv/sync_file_receive_deframer_test.sv
// Self-checking testbench for the file-receive deframer: directed cases and random
// file sessions over valid/ready words, checked against an in-bench slot model.
// Depends on sfrd_pkg and sync_file_receive_deframer.
module sync_file_receive_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT     = 4;
    localparam int RANDOM_ITEMS   = 800;
    localparam int IDLE_LIMIT     = 2000;
    localparam int HOLD_AT_WORD   = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_AT_EVENT = 700;
    localparam int SETTLE_CYCLES  = 16;
    localparam int SCRIPT_MAX     = 128;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    sfrd_pkg::item_t   item;
    logic              result_valid;
    logic              result_ready;
    sfrd_pkg::result_t result;

    // Slot model used to predict the result words.
    logic [2:0]  slot_phase  [SLOT_COUNT];
    logic [31:0] slot_left   [SLOT_COUNT];
    logic [63:0] slot_header [SLOT_COUNT];

    sfrd_pkg::item_t   queued_events [$];
    sfrd_pkg::result_t due_results   [$];

    // Per-slot session scripts used while building the stimulus.
    sfrd_pkg::item_t script_mem [SLOT_COUNT][SCRIPT_MAX];
    int              script_len [SLOT_COUNT];
    int              script_pos [SLOT_COUNT];

    bit item_hs     = 1'b0;
    bit result_hs   = 1'b0;
    int events_taken = 0;
    int words_seen   = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;
    int send_gap     = 0;
    int take_gap     = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    sync_file_receive_deframer #(.SLOTS(SLOT_COUNT)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic post(logic [2:0] kind, int s, logic [7:0] b, logic cl);
        sfrd_pkg::result_t r;
        r = '0;
        r.kind          = kind;
        r.result_slot   = 2'(s);
        r.payload_byte  = b;
        r.close_channel = cl;
        due_results.push_back(r);
    endtask

    task automatic vacate(int s);
        slot_phase[s]  = sfrd_pkg::PH_FREE;
        slot_left[s]   = '0;
        slot_header[s] = '0;
    endtask

    task automatic header_complete(int s, logic end_flag);
        logic [31:0] id;
        logic [31:0] size;
        id   = slot_header[s][31:0];
        size = slot_header[s][63:32];
        if (id == sfrd_pkg::TAG_DATA || id == sfrd_pkg::TAG_DONE)
        begin
            if (size != 0)
            begin
                slot_phase[s] = sfrd_pkg::PH_DATA;
                slot_left[s]  = size;
            end
            else if (id == sfrd_pkg::TAG_DATA)
                slot_left[s] = sfrd_pkg::HDR_LEN;
            else
            begin
                post(end_flag ? sfrd_pkg::KIND_EOF : sfrd_pkg::KIND_ERROR, s, 8'h00, 1'b1);
                vacate(s);
            end
        end
        else if (id == sfrd_pkg::TAG_FAIL && size != 0)
        begin
            slot_phase[s] = sfrd_pkg::PH_FAIL;
            slot_left[s]  = size;
        end
        else
        begin
            post(sfrd_pkg::KIND_ERROR, s, 8'h00, 1'b1);
            vacate(s);
        end
    endtask

    task automatic take_rx(int s, logic [7:0] b, logic end_flag);
        logic [31:0] left;
        int          pos;
        left = slot_left[s];
        case (slot_phase[s])
            sfrd_pkg::PH_HEAD:
            begin
                pos = (left == 0 || left > sfrd_pkg::HDR_LEN) ? 0
                    : int'(sfrd_pkg::HDR_LEN - left);
                slot_header[s][pos*8 +: 8] = b;
                left = (left > 1) ? left - 1 : 32'd0;
                slot_left[s] = left;
                if (left == 0)
                    header_complete(s, end_flag);
            end
            sfrd_pkg::PH_DATA:
            begin
                post(sfrd_pkg::KIND_PAYLOAD, s, b, 1'b0);
                left = (left > 1) ? left - 1 : 32'd0;
                slot_left[s] = left;
                if (left == 0)
                begin
                    if (slot_header[s][31:0] == sfrd_pkg::TAG_DONE)
                    begin
                        // A DONE payload only ends the file on a chunk boundary.
                        post(end_flag ? sfrd_pkg::KIND_EOF : sfrd_pkg::KIND_ERROR,
                             s, 8'h00, 1'b1);
                        vacate(s);
                    end
                    else
                    begin
                        slot_phase[s] = sfrd_pkg::PH_HEAD;
                        slot_left[s]  = sfrd_pkg::HDR_LEN;
                    end
                end
            end
            sfrd_pkg::PH_FAIL:
            begin
                left = (left > 1) ? left - 1 : 32'd0;
                slot_left[s] = left;
                if (left == 0)
                begin
                    post(sfrd_pkg::KIND_ERROR, s, 8'h00, 1'b1);
                    vacate(s);
                end
            end
            default:
            begin
                post(sfrd_pkg::KIND_ERROR, s, 8'h00, 1'b1);
                vacate(s);
            end
        endcase
    endtask

    task automatic deframe_event(sfrd_pkg::item_t w);
        int                first;
        int                s;
        int                mark;
        sfrd_pkg::result_t r;
        mark = due_results.size();
        s    = int'(w.slot);
        if (w.opcode == sfrd_pkg::OP_OPEN)
        begin
            first = -1;
            for (int i = SLOT_COUNT - 1; i >= 0; i--)
                if (slot_phase[i] == sfrd_pkg::PH_FREE)
                    first = i;
            if (first >= 0)
            begin
                vacate(first);
                slot_phase[first] = sfrd_pkg::PH_OPEN;
                post(sfrd_pkg::KIND_OPENED, first, 8'h00, 1'b0);
            end
            else
                post(sfrd_pkg::KIND_NOFREE, 0, 8'h00, 1'b0);
        end
        else if (w.opcode <= sfrd_pkg::OP_CLOSE && s < SLOT_COUNT)
        begin
            case (w.opcode)
                sfrd_pkg::OP_READY:
                    if (slot_phase[s] == sfrd_pkg::PH_OPEN)
                    begin
                        slot_phase[s] = sfrd_pkg::PH_HEAD;
                        slot_left[s]  = sfrd_pkg::HDR_LEN;
                        post(sfrd_pkg::KIND_SEND, s, 8'h00, 1'b0);
                    end
                sfrd_pkg::OP_BYTE:
                    take_rx(s, w.rx_byte, w.chunk_end);
                sfrd_pkg::OP_LOST:
                begin
                    post(sfrd_pkg::KIND_ERROR, s, 8'h00, 1'b0);
                    vacate(s);
                end
                default:
                    if (slot_phase[s] != sfrd_pkg::PH_FREE)
                    begin
                        post(sfrd_pkg::KIND_ERROR, s, 8'h00, 1'b1);
                        vacate(s);
                    end
            endcase
        end
        if (due_results.size() > mark)
        begin
            r = due_results.pop_back();
            r.last_result = 1'b1;
            due_results.push_back(r);
        end
    endtask

    task automatic check_word(sfrd_pkg::result_t got);
        sfrd_pkg::result_t want;
        if (due_results.size() == 0)
        begin
            $error("result word with nothing expected: kind %0d slot %0d",
                   got.kind, got.result_slot);
            mismatches++;
        end
        else
        begin
            want = due_results.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.result_slot !== want.result_slot)
            begin
                $error("result_slot: expected %0d, got %0d", want.result_slot, got.result_slot);
                mismatches++;
            end
            if (got.payload_byte !== want.payload_byte)
            begin
                $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
                mismatches++;
            end
            if (got.close_channel !== want.close_channel)
            begin
                $error("close_channel: expected %0b, got %0b", want.close_channel,
                       got.close_channel);
                mismatches++;
            end
            if (got.last_result !== want.last_result)
            begin
                $error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
                mismatches++;
            end
        end
    endtask

    // Idle lengths come in stretches: none, uniform, or rare.
    function automatic int draw_gap(int n);
        case ((n / 64) % 3)
            0:       return 0;
            1:       return int'($urandom_range(0, 18));
            default: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 18)) : 0;
        endcase
    endfunction

    function automatic sfrd_pkg::item_t event_word(logic [2:0] op, int s, logic [7:0] b,
                                                   logic e);
        sfrd_pkg::item_t w;
        w.opcode    = op;
        w.slot      = 2'(s);
        w.rx_byte   = b;
        w.chunk_end = e;
        return w;
    endfunction

    task automatic offer(logic [2:0] op, int s, logic [7:0] b, logic e);
        queued_events.push_back(event_word(op, s, b, e));
    endtask

    function automatic bit in_session(int s);
        return script_pos[s] < script_len[s];
    endfunction

    task automatic plan_add(int s, sfrd_pkg::item_t w);
        script_mem[s][script_len[s]] = w;
        script_len[s]++;
    endtask

    task automatic plan_header(int s, logic [31:0] id, logic [31:0] size, logic end_last);
        logic [63:0] hdr;
        hdr = {size, id};
        for (int i = 0; i < 8; i++)
            plan_add(s, event_word(sfrd_pkg::OP_BYTE, s, hdr[i*8 +: 8],
                                   (i == 7) ? end_last : 1'($urandom_range(0, 1))));
    endtask

    task automatic plan_payload(int s, int n, logic end_last);
        for (int i = 0; i < n; i++)
            plan_add(s, event_word(sfrd_pkg::OP_BYTE, s, 8'($urandom),
                                   (i == n - 1) ? end_last : 1'($urandom_range(0, 1))));
    endtask

    // One session for slot s, from open to the word that frees the slot.
    task automatic plan_session(int s);
        int          pick;
        int          n;
        int          cut;
        logic        done_end;
        logic [31:0] id;
        script_len[s] = 0;
        script_pos[s] = 0;
        plan_add(s, event_word(sfrd_pkg::OP_OPEN, int'($urandom_range(0, 3)), 8'($urandom),
                               1'($urandom_range(0, 1))));
        pick = int'($urandom_range(0, 99));
        if (pick >= 90)
            plan_add(s, event_word(sfrd_pkg::OP_BYTE, s, 8'($urandom),
                                   1'($urandom_range(0, 1))));
        else
        begin
            plan_add(s, event_word(sfrd_pkg::OP_READY, s, 8'($urandom),
                                   1'($urandom_range(0, 1))));
            if (pick < 65)
            begin
                repeat ($urandom_range(0, 2))
                begin
                    n = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
                    plan_header(s, sfrd_pkg::TAG_DATA, n, 1'($urandom_range(0, 1)));
                    plan_payload(s, n, 1'($urandom_range(0, 1)));
                end
                n = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
                done_end = (pick < 55);
                plan_header(s, sfrd_pkg::TAG_DONE, n,
                            (n == 0) ? done_end : 1'($urandom_range(0, 1)));
                plan_payload(s, n, done_end);
            end
            else if (pick < 75)
            begin
                n = int'($urandom_range(0, 4));
                plan_header(s, sfrd_pkg::TAG_FAIL, n, 1'($urandom_range(0, 1)));
                plan_payload(s, n, 1'($urandom_range(0, 1)));
            end
            else
            begin
                id = ($urandom_range(0, 3) == 0) ? sfrd_pkg::TAG_RECV : $urandom;
                if (id == sfrd_pkg::TAG_DATA || id == sfrd_pkg::TAG_DONE
                    || id == sfrd_pkg::TAG_FAIL)
                    id = sfrd_pkg::TAG_RECV;
                plan_header(s, id, $urandom_range(0, 8), 1'($urandom_range(0, 1)));
            end
        end
        // Some sessions are cut short by a lost channel or a software close.
        if ($urandom_range(0, 6) == 0)
        begin
            cut = int'($urandom_range(1, script_len[s] - 1));
            script_len[s] = cut;
            plan_add(s, event_word(($urandom_range(0, 1) != 0) ? sfrd_pkg::OP_LOST
                                                               : sfrd_pkg::OP_CLOSE,
                                   s, 8'($urandom), 1'($urandom_range(0, 1))));
        end
    endtask

    task automatic issue_next(int s);
        queued_events.push_back(script_mem[s][script_pos[s]]);
        script_pos[s]++;
    endtask

    always @(posedge clk)
    begin
        item_hs   = (rst_n === 1'b1) && item_valid && item_ready;
        result_hs = (rst_n === 1'b1) && result_valid && result_ready;
        if (item_hs)
        begin
            deframe_event(item);
            events_taken++;
        end
        if (result_hs)
        begin
            check_word(result);
            words_seen++;
        end
        if (item_hs || result_hs)
            quiet_cycles = 0;
        else if (rst_n === 1'b1)
        begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Sender: holds a word until it is taken, then idles for the drawn gap.
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && !(item_valid && !item_hs))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (queued_events.size() > 0 &&
                     !(events_taken == DRAIN_AT_EVENT && due_results.size() > 0))
            begin
                item       <= queued_events.pop_front();
                item_valid <= 1'b1;
                send_gap = draw_gap(events_taken);
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold that backs up the block.
    always @(negedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (words_seen == HOLD_AT_WORD && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (result_hs)
                take_gap = draw_gap(words_seen + 32);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (take_gap > 0)
            begin
                take_gap--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin
        int          s;
        int          r;
        int          made;
        int          lowest;
        int          total;
        logic [63:0] hdr;
        logic [2:0]  noise_op;

        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            vacate(i);
            script_len[i] = 0;
            script_pos[i] = 0;
        end

        // Directed: a one-byte file, then open exhaustion and each way a slot ends.
        offer(sfrd_pkg::OP_OPEN, 3, 8'hFF, 1'b1);
        offer(sfrd_pkg::OP_READY, 0, 8'h00, 1'b0);
        offer(sfrd_pkg::OP_READY, 0, 8'h00, 1'b0);
        hdr = {32'd1, sfrd_pkg::TAG_DONE};
        for (int i = 0; i < 8; i++)
            offer(sfrd_pkg::OP_BYTE, 0, hdr[i*8 +: 8], 1'b0);
        offer(sfrd_pkg::OP_BYTE, 0, 8'hFF, 1'b1);
        offer(sfrd_pkg::OP_BYTE, 0, 8'h00, 1'b1);
        repeat (5)
            offer(sfrd_pkg::OP_OPEN, 0, 8'h00, 1'b0);
        offer(sfrd_pkg::OP_BYTE, 1, 8'h55, 1'b0);
        offer(sfrd_pkg::OP_LOST, 2, 8'h00, 1'b0);
        offer(sfrd_pkg::OP_CLOSE, 3, 8'h00, 1'b0);
        offer(sfrd_pkg::OP_CLOSE, 1, 8'h00, 1'b0);
        offer(3'(sfrd_pkg::OP_CLOSE + 3), 2, 8'hAA, 1'b1);
        offer(sfrd_pkg::OP_LOST, 0, 8'h00, 1'b0);
        offer(sfrd_pkg::OP_READY, 2, 8'h00, 1'b0);

        // Random: interleaved sessions on all slots with some stray words.
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            lowest = -1;
            for (int i = SLOT_COUNT - 1; i >= 0; i--)
                if (!in_session(i))
                    lowest = i;
            r = int'($urandom_range(0, 99));
            if (r < 8)
            begin
                if (lowest < 0)
                    offer(sfrd_pkg::OP_OPEN, int'($urandom_range(0, 3)), 8'($urandom), 1'b0);
                else if ($urandom_range(0, 1) != 0)
                    offer(3'(sfrd_pkg::OP_CLOSE + $urandom_range(1, 3)),
                          int'($urandom_range(0, 3)),
                          8'($urandom), 1'($urandom_range(0, 1)));
                else
                begin
                    do
                        s = int'($urandom_range(0, SLOT_COUNT - 1));
                    while (in_session(s));
                    case ($urandom_range(0, 3))
                        0:       noise_op = sfrd_pkg::OP_BYTE;
                        1:       noise_op = sfrd_pkg::OP_READY;
                        2:       noise_op = sfrd_pkg::OP_LOST;
                        default: noise_op = sfrd_pkg::OP_CLOSE;
                    endcase
                    offer(noise_op, s, 8'($urandom), 1'($urandom_range(0, 1)));
                end
            end
            else if (lowest >= 0 && (lowest == 0 && !in_session(1) && !in_session(2) &&
                                     !in_session(3) || r < 16))
            begin
                plan_session(lowest);
                issue_next(lowest);
                made++;
            end
            else if (lowest != 0 || in_session(0))
            begin
                do
                    s = int'($urandom_range(0, SLOT_COUNT - 1));
                while (!in_session(s));
                issue_next(s);
                made++;
            end
        end
        for (int i = 0; i < SLOT_COUNT; i++)
            while (in_session(i))
                issue_next(i);
        total = queued_events.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (!(events_taken == total && due_results.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
